// ===== rtl/tsd_pkg.sv =====
package tsd_pkg;

  localparam int BYTE_W        = 8;
  localparam int SCRATCH_BYTES = 9;
  localparam int POS_W         = 4;
  localparam int TEMP_W        = 21;
  localparam int QUO_W         = 16;
  localparam int BIT_CNT_W     = 3;

  localparam logic [BYTE_W-1:0] FAM_16BIT   = 8'h28;
  localparam logic [BYTE_W-1:0] FAM_HALFDEG = 8'h10;
  localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h8C;

  // quarter degree in 1/256 units
  localparam logic [TEMP_W-1:0] QUARTER_Q8  = TEMP_W'(64);

  typedef enum logic [1:0] {
    ST_OK,
    ST_CRC_ERR,
    ST_UNKNOWN_FAMILY,
    ST_ZERO_DIVISOR
  } status_t;

endpackage

// ===== rtl/tsd_serial_div.sv =====
module tsd_serial_div
  import tsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUO_W-1:0]  dividend,
  input  logic [BYTE_W-1:0] divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(QUO_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0] rem;
  logic [QUO_W-1:0]  quo;
  logic [BYTE_W-1:0] dvs;

  logic [BYTE_W:0]   trial;
  logic [BYTE_W:0]   trial_sub;
  logic              fits;

  // restoring division, one quotient bit per cycle
  assign trial     = {rem, quo[QUO_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = trial >= {1'b0, dvs};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[BYTE_W-1:0] : trial[BYTE_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) done |-> rem < dvs)
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/thermometer_scratchpad_decoder.sv =====
// channel | signals                                           | accepted when
// input   | data_byte, family_code, frame_start, in_valid/in_ready | in_valid & in_ready
// output  | status, temperature_q8, out_valid/out_ready        | out_valid & out_ready
//
// Each byte is accepted, then shifted bit by bit through the bit-serial CRC-8;
// no new byte is taken until that is done. The ninth byte of a 0x10 frame with
// a good CRC and nonzero byte 7 then runs the bit-serial divider (16 quotient bits
// plus load) before the result moves out; other final bytes move out directly.
// A waiting result does not block input; only a new result waits for it.
// rst is synchronous and clears the frame position, CRC and handshake state.
module thermometer_scratchpad_decoder
  import tsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [BYTE_W-1:0] family_code,
  input  logic              frame_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic signed [TEMP_W-1:0] temperature_q8
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CRC,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state;
  logic [POS_W-1:0]   pos;
  logic [BYTE_W-1:0]  crc;
  logic [BYTE_W-1:0]  crc_sh;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic               last;
  logic [BYTE_W-1:0]  latched_family;
  logic [BYTE_W-1:0]  b0, b1, b6, b7;
  logic               neg;
  status_t            res_status;
  logic [TEMP_W-1:0]  res_temp;
  status_t            out_status;
  logic [TEMP_W-1:0]  out_temp;

  logic               restart;
  logic [POS_W-1:0]   pos_cur;
  logic [BYTE_W-1:0]  crc_cur;
  logic [BYTE_W-1:0]  crc_step;
  logic               bit_last;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic               frac_neg;
  logic [BYTE_W-1:0]  diff_mag;
  logic [BYTE_W-1:0]  whole;
  logic [QUO_W:0]     frac_s;
  logic [TEMP_W-1:0]  temp_16bit;
  logic [TEMP_W-1:0]  temp_half;
  logic               out_load;

  assign in_ready = (state == S_IDLE);

  assign restart = frame_start || (pos >= POS_W'(SCRATCH_BYTES));
  assign pos_cur = restart ? '0 : pos;
  assign crc_cur = restart ? '0 : crc;

  assign crc_step = crc_sh[0] ? ((crc_sh >> 1) ^ CRC_POLY) : (crc_sh >> 1);
  assign bit_last = (bit_cnt == BIT_CNT_W'(BYTE_W - 1));

  // fraction sign: remaining count above the per-degree count gives a negative numerator
  assign frac_neg = b6 > b7;
  assign diff_mag = frac_neg ? (b6 - b7) : (b7 - b6);

  assign div_start = (state == S_CRC) && bit_last && last && (crc_step == '0) &&
                     (latched_family != FAM_16BIT) && (latched_family == FAM_HALFDEG) &&
                     (b7 != '0);

  tsd_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_mag, {BYTE_W{1'b0}}}),
    .divisor  (b7),
    .done     (div_done),
    .quotient (div_quo)
  );

  // floor of the 9-bit value {sign, byte0} halved
  assign whole = {(b1 != '0), b0[BYTE_W-1:1]};
  assign frac_s = neg ? (-{1'b0, div_quo}) : {1'b0, div_quo};

  assign temp_16bit = {{(TEMP_W-2*BYTE_W-4){b1[BYTE_W-1]}}, b1, b0, 4'h0};
  assign temp_half  = {{(TEMP_W-2*BYTE_W){whole[BYTE_W-1]}}, whole, {BYTE_W{1'b0}}}
                      - QUARTER_Q8
                      + {{(TEMP_W-QUO_W-1){frac_s[QUO_W]}}, frac_s};

  // output register takes a new result when empty or being drained
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pos            <= '0;
      crc            <= '0;
      bit_cnt        <= '0;
      last           <= 1'b0;
      latched_family <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            crc_sh  <= crc_cur ^ data_byte;
            bit_cnt <= '0;
            last    <= (pos_cur == POS_W'(SCRATCH_BYTES - 1));
            pos     <= pos_cur + 1'b1;
            if (pos_cur == '0) begin
              latched_family <= family_code;
              b0 <= data_byte;
            end
            if (pos_cur == POS_W'(1)) b1 <= data_byte;
            if (pos_cur == POS_W'(6)) b6 <= data_byte;
            if (pos_cur == POS_W'(7)) b7 <= data_byte;
            state <= S_CRC;
          end
        end
        S_CRC: begin
          crc_sh  <= crc_step;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_last) begin
            if (!last) begin
              crc   <= crc_step;
              state <= S_IDLE;
            end else begin
              crc <= '0;
              pos <= '0;
              neg <= frac_neg;
              if (crc_step != '0) begin
                res_status <= ST_CRC_ERR;
                res_temp   <= '0;
                state      <= S_OUT;
              end else if (latched_family == FAM_16BIT) begin
                res_status <= ST_OK;
                res_temp   <= temp_16bit;
                state      <= S_OUT;
              end else if (latched_family == FAM_HALFDEG) begin
                if (b7 == '0) begin
                  res_status <= ST_ZERO_DIVISOR;
                  res_temp   <= '0;
                  state      <= S_OUT;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_DIV;
                end
              end else begin
                res_status <= ST_UNKNOWN_FAMILY;
                res_temp   <= '0;
                state      <= S_OUT;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_temp <= temp_half;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_status <= res_status;
            out_temp   <= res_temp;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status         = out_status;
  assign temperature_q8 = out_temp;

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_OK) |-> out_temp == '0)
    else $error("nonzero temperature with error status");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(SCRATCH_BYTES))
    else $error("frame position out of range");
  a_accept_to_crc: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_CRC)
    else $error("accepted item did not enter CRC");
  a_div_only_halfdeg: assert property (@(posedge clk) disable iff (rst)
    div_start |-> latched_family == FAM_HALFDEG && b7 != '0)
    else $error("divider started outside half-degree conversion");

endmodule
